// ===== hdl/afl_pkg.sv =====
// Shared widths and word types of the audio frame level feature block.
package afl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CROSS_W    = 10;
  localparam int ZCR_W      = 17;
  localparam int ZCR_FRAC_W = 16;
  localparam int RMS_W      = 16;
  localparam int PEAK_W     = 16;
  localparam int LEN_W      = 11;
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = 32;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic [CROSS_W-1:0] crossings;
    logic [ZCR_W-1:0]   zcr_q16;
    logic [RMS_W-1:0]   rms_q15;
    logic [PEAK_W-1:0]  peak_q15;
    logic [LEN_W-1:0]   frame_length;
    logic               overflow;
  } out_word_t;

endpackage

// ===== hdl/afl_stream_if.sv =====
// Valid/ready stream channel that carries one word per handshake.
interface afl_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== hdl/afl_front.sv =====
// Front end: takes samples and accumulates crossings, energy, peak and length per frame.
module afl_front import afl_pkg::*; #(
  parameter int FRAME_CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  afl_stream_if.sink           in_stream,
  output logic                 q_push,
  output logic [2*$clog2(FRAME_CAPACITY+1)+2*(SAMPLE_W-1)+$clog2(FRAME_CAPACITY+1)
                +PEAK_W:0]     q_data,
  input  logic                 q_full
);

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
  localparam int SUM_W = 2 * (SAMPLE_W - 1) + CNT_W;

  logic [SAMPLE_W-1:0] raw;
  logic                neg;
  logic [PEAK_W-1:0]   mag;
  logic                take;

  logic                s1_v_r;
  logic [SQ_W-1:0]     s1_sq_r;
  logic [PEAK_W-1:0]   s1_mag_r;
  logic                s1_neg_r;
  logic                s1_last_r;
  logic                s1_go;
  logic                room;

  logic                prev_neg_r, prev_neg_nxt;
  logic [CNT_W-1:0]    cross_r, cross_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PEAK_W-1:0]   peak_r, peak_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;

  assign raw  = in_stream.data.sample;
  assign neg  = raw[SAMPLE_W-1];
  assign mag  = neg ? PEAK_W'(~raw + 1'b1) : raw;

  assign s1_go           = s1_v_r && !(s1_last_r && q_full);
  assign in_stream.ready = !s1_v_r || s1_go;
  assign take            = in_stream.valid && in_stream.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_stream.ready) begin
      s1_v_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sq_r   <= SQ_W'(mag) * SQ_W'(mag);
      s1_mag_r  <= mag;
      s1_neg_r  <= neg;
      s1_last_r <= in_stream.data.last;
    end
  end

  assign room = cnt_r < CNT_W'(FRAME_CAPACITY);

  always_comb begin
    prev_neg_nxt = prev_neg_r;
    cross_nxt    = cross_r;
    sum_nxt      = sum_r;
    peak_nxt     = peak_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    if (room) begin
      if (cnt_r != '0 && s1_neg_r != prev_neg_r) begin
        cross_nxt = cross_r + 1'b1;
      end
      prev_neg_nxt = s1_neg_r;
      sum_nxt      = sum_r + SUM_W'(s1_sq_r);
      if (s1_mag_r > peak_r) begin
        peak_nxt = s1_mag_r;
      end
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign q_push = s1_go && s1_last_r;
  assign q_data = {cross_nxt, sum_nxt, peak_nxt, cnt_nxt, ovf_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_neg_r <= 1'b0;
      cross_r    <= '0;
      sum_r      <= '0;
      peak_r     <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        prev_neg_r <= 1'b0;
        cross_r    <= '0;
        sum_r      <= '0;
        peak_r     <= '0;
        cnt_r      <= '0;
        ovf_r      <= 1'b0;
      end else begin
        prev_neg_r <= prev_neg_nxt;
        cross_r    <= cross_nxt;
        sum_r      <= sum_nxt;
        peak_r     <= peak_nxt;
        cnt_r      <= cnt_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_CAPACITY))
    else $error("sample count passed the frame capacity");

  a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (cnt_nxt != '0 && cross_nxt < cnt_nxt))
    else $error("closed frame has no samples or too many crossings");
`endif

endmodule

// ===== hdl/afl_queue.sv =====
// Two-entry queue of closed frame summaries between the front and back ends.
module afl_queue import afl_pkg::*; #(
  parameter int WIDTH = 68
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0]           mem_r [DEPTH];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [$clog2(DEPTH+1)-1:0] count_r;
  logic                       do_push;
  logic                       do_pop;

  assign full     = count_r == DEPTH[$clog2(DEPTH+1)-1:0];
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame summary pushed into a full queue");
`endif

endmodule

// ===== hdl/afl_back.sv =====
// Back end: divides for the crossing rate and mean square, takes the square root, holds the result.
module afl_back import afl_pkg::*; #(
  parameter int FRAME_CAPACITY = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [2*$clog2(FRAME_CAPACITY+1)+2*(SAMPLE_W-1)+$clog2(FRAME_CAPACITY+1)
                +PEAK_W:0]     q_data,
  output logic                 q_pop,
  afl_stream_if.source         out_stream
);

  localparam int CNT_W  = $clog2(FRAME_CAPACITY + 1);
  localparam int SUM_W  = 2 * (SAMPLE_W - 1) + CNT_W;
  localparam int ZD_W   = CNT_W + ZCR_FRAC_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_OUT} state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic [CNT_W-1:0]    q_cross;
  logic [SUM_W-1:0]    q_sum;
  logic [PEAK_W-1:0]   q_peak;
  logic [CNT_W-1:0]    q_len;
  logic                q_ovf;

  logic [CNT_W-1:0]    cross_r, cross_nxt;
  logic [PEAK_W-1:0]   peak_r, peak_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic                ovf_r, ovf_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]    sd_r, sd_nxt;
  logic [CNT_W-1:0]    rem_s_r, rem_s_nxt;
  logic [ZD_W-1:0]     zd_r, zd_nxt;
  logic [CNT_W-1:0]    rem_z_r, rem_z_nxt;
  logic [ROOT_W-1:0]   v_r, v_nxt;
  logic [ROOT_W-1:0]   res_r, res_nxt;
  logic [ROOT_W-1:0]   bit_r, bit_nxt;

  logic [CNT_W:0]      trial_s;
  logic [CNT_W:0]      trial_z;
  logic [CNT_W-1:0]    len_m1;
  logic                ge_s;
  logic                ge_z;
  logic [ROOT_W-1:0]   rb;
  logic                ge_r;

  assign {q_cross, q_sum, q_peak, q_len, q_ovf} = q_data;

  assign q_pop            = (state_r == ST_IDLE) && q_valid;
  assign out_stream.valid = out_valid_r;
  assign out_stream.data  = out_word_r;

  assign len_m1  = len_r - 1'b1;
  assign trial_s = {rem_s_r, sd_r[SUM_W-1]};
  assign trial_z = {rem_z_r, zd_r[ZD_W-1]};
  assign ge_s    = trial_s >= {1'b0, len_r};
  assign ge_z    = trial_z >= {1'b0, len_m1};
  assign rb      = res_r + bit_r;
  assign ge_r    = v_r >= rb;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    cross_nxt     = cross_r;
    peak_nxt      = peak_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    step_nxt      = step_r;
    sd_nxt        = sd_r;
    rem_s_nxt     = rem_s_r;
    zd_nxt        = zd_r;
    rem_z_nxt     = rem_z_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cross_nxt = q_cross;
          peak_nxt  = q_peak;
          len_nxt   = q_len;
          ovf_nxt   = q_ovf;
          sd_nxt    = q_sum;
          zd_nxt    = {q_cross, ZCR_FRAC_W'(0)};
          rem_s_nxt = '0;
          rem_z_nxt = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_s_nxt = ge_s ? CNT_W'(trial_s - {1'b0, len_r}) : CNT_W'(trial_s);
        sd_nxt    = {sd_r[SUM_W-2:0], ge_s};
        if (step_r < STEP_W'(ZD_W)) begin
          rem_z_nxt = ge_z ? CNT_W'(trial_z - {1'b0, len_m1}) : CNT_W'(trial_z);
          zd_nxt    = {zd_r[ZD_W-2:0], ge_z};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          v_nxt     = ROOT_W'(sd_nxt);
          res_nxt   = '0;
          bit_nxt   = ROOT_W'(1) << (ROOT_W - 2);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (ge_r) begin
          v_nxt   = v_r - rb;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          out_word_nxt.crossings    = CROSS_W'(cross_r);
          out_word_nxt.zcr_q16      = (len_r < CNT_W'(2)) ? '0 : ZCR_W'(zd_r);
          out_word_nxt.rms_q15      = RMS_W'(res_nxt);
          out_word_nxt.peak_q15     = peak_r;
          out_word_nxt.frame_length = LEN_W'(len_r);
          out_word_nxt.overflow     = ovf_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_stream.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_word_r  <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cross_r <= cross_nxt;
    peak_r  <= peak_nxt;
    len_r   <= len_nxt;
    ovf_r   <= ovf_nxt;
    step_r  <= step_nxt;
    sd_r    <= sd_nxt;
    rem_s_r <= rem_s_nxt;
    zd_r    <= zd_nxt;
    rem_z_r <= rem_z_nxt;
    v_r     <= v_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
  end

`ifndef SYNTH
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_s_r < len_r)
    else $error("mean square remainder not below the frame length");

  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> $onehot(bit_r))
    else $error("square root step bit is not a single bit");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.rms_q15 <= 16'd32768 && out_word_r.zcr_q16 <= 17'd65536))
    else $error("result word out of range");
`endif

endmodule

// ===== hdl/audio_frame_level_features_core.sv =====
// Top level of the audio frame level feature block: zero-crossing rate, RMS and peak per frame.
// The input side takes one signed 16-bit sample per clock, with no bubbles while the queue has
// room: a two-stage front end squares each sample and accumulates crossings, energy, peak and
// length, and a frame's summary goes into a two-entry queue on the sample that carries last. The
// back end works on one frame at a time: it loads the summary, runs a one-bit-per-cycle divider
// pair, then a bit-pair square root, and the result word waits in the output register until it
// is taken. When short frames arrive back to back faster than the back end finishes them, the
// queue fills and the input stalls on the last sample of a frame until a queue entry frees up.
// There is no clearing pass after reset.
module audio_frame_level_features_core import afl_pkg::*; #(
  parameter int FRAME_CAPACITY = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  afl_stream_if.sink   in_stream,
  afl_stream_if.source out_stream
);

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);
  localparam int SUM_W = 2 * (SAMPLE_W - 1) + CNT_W;
  localparam int REC_W = 2 * CNT_W + SUM_W + PEAK_W + 1;

  logic             q_push;
  logic [REC_W-1:0] q_wdata;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  logic [REC_W-1:0] q_rdata;

  afl_front #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  afl_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (q_rdata)
  );

  afl_back #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
